>>> src/keyword_substitution_cipher_unit_macros.svh
// Assertion macros used by the keyword substitution cipher top level
`ifndef KEYWORD_SUBSTITUTION_CIPHER_UNIT_MACROS_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define KSCU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kscu assertion failed");

`define KSCU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kscu assertion failed");

`else

`define KSCU_ASSERT_NOW(label, ante, cons)

`define KSCU_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> src/kscu_pkg.sv
// Shared constants, codes and types of the keyword substitution cipher
`default_nettype none

package kscu_pkg;

  localparam int ALPHABET_SIZE = 26;
  localparam int CHAR_W        = 8;
  localparam int ACTION_W      = 2;

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] LETTER_A   = 8'h41;

  localparam logic [ACTION_W-1:0] ACT_KEY = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ENC = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DEC = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_FILL = 2'b10
  } state_t;

  typedef struct packed {
    logic              clear;
    logic              push;
    logic [CHAR_W-1:0] push_data;
    logic [CHAR_W-1:0] cmp_char;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> src/kscu_cell.sv
// One table cell: holds an entry and its valid flag, appends when it is the first free cell
`default_nettype none

module kscu_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire kscu_pkg::cell_ctl_t        ctl,
  input  wire logic                       prev_ok,
  output logic                            valid,
  output logic [kscu_pkg::CHAR_W-1:0]     entry,
  output logic                            match
);

  logic                          valid_r;
  logic                          valid_nxt;
  logic [kscu_pkg::CHAR_W-1:0]   entry_r;
  logic                          own_valid;
  logic                          wr;

  assign own_valid = valid_r & ~ctl.clear;
  assign wr        = ctl.push & prev_ok & ~own_valid;
  assign valid_nxt = own_valid | wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      entry_r <= ctl.push_data;
    end
  end

  assign valid = valid_r;
  assign entry = entry_r;
  assign match = valid_r & (entry_r == ctl.cmp_char);

endmodule

`default_nettype wire

>>> src/keyword_substitution_cipher_unit.sv
// Keyword substitution cipher: top level with the cell chain, fill sequencer and output stage
//
// Usage:
//   Input channel in_valid/in_stall carries in_action, in_char and in_key_last.
//   Action key appends a new non-space key byte to the table (no result); encrypt and decrypt
//   each give at most one result on out_valid/out_char, in request order.
//   A new message request or ordinary key byte is taken every cycle while
//   the result side keeps up; a result is registered in the output register,
//   or in the skid register when the output register is held.
//   A key byte with in_key_last set starts a letter fill that walks Z down to A,
//   one letter per cycle in the cell chain; in_stall stays high until the fill ends.
//   The table is a chain of 26 cells; each cell appends only when its lower
//   neighbor is filled, compares its entry with the byte for the duplicate
//   check and for decryption in the same cycle.
//   When the receiver stalls, a result waits in the output register and one
//   more in a skid register; on the output side, in_stall rises only once the skid register holds.
//   Reset (rst_n low, synchronous) empties the table, clears the seen letters
//   and the key-finished flag and drops pending results; table contents
//   themselves are not cleared.
`default_nettype none
`include "keyword_substitution_cipher_unit_macros.svh"

module keyword_substitution_cipher_unit #(
  parameter int N_CELLS = kscu_pkg::ALPHABET_SIZE
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [kscu_pkg::ACTION_W-1:0] in_action,
  input  wire logic [kscu_pkg::CHAR_W-1:0]   in_char,
  input  wire logic                          in_key_last,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [kscu_pkg::CHAR_W-1:0]        out_char
);

  localparam int IDX_W = $clog2(N_CELLS);
  localparam int CW    = kscu_pkg::CHAR_W;

  kscu_pkg::state_t   state_r, state_nxt;
  logic [IDX_W-1:0]   let_r, let_nxt;
  logic [N_CELLS-1:0] seen_r, seen_nxt;
  logic               key_done_r, key_done_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [CW-1:0]      out_char_r, out_char_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  logic [CW-1:0]      skid_char_r, skid_char_nxt;

  kscu_pkg::cell_ctl_t ctl;
  logic [N_CELLS-1:0] cell_valid;
  logic [N_CELLS-1:0] cell_match;
  logic [N_CELLS-1:0] chain_ok;
  logic [CW-1:0]      cell_entry [N_CELLS];

  logic               in_acc;
  logic               acc_key;
  logic               is_upper;
  logic [IDX_W-1:0]   chr_idx;
  logic [CW-1:0]      chr_off;
  logic               held;
  logic [IDX_W-1:0]   dec_idx;
  logic               res_vld;
  logic [CW-1:0]      res_char;
  logic               out_take;

  assign in_stall = (state_r != kscu_pkg::ST_IDLE) | skid_valid_r;
  assign in_acc   = in_valid & ~in_stall;
  assign acc_key  = in_acc & (in_action == kscu_pkg::ACT_KEY);

  assign chr_off  = in_char - kscu_pkg::LETTER_A;
  assign chr_idx  = chr_off[IDX_W-1:0];
  assign is_upper = (in_char >= kscu_pkg::LETTER_A) &&
                    ({1'b0, in_char} < ({1'b0, kscu_pkg::LETTER_A} + (CW+1)'(N_CELLS)));
  assign held     = (|cell_match) & ~key_done_r;

  genvar g;
  generate
    for (g = 0; g < N_CELLS; g++) begin : g_cell
      if (g == 0) begin : g_head
        assign chain_ok[g] = 1'b1;
      end else begin : g_body
        assign chain_ok[g] = cell_valid[g-1] & ~ctl.clear;
      end
      kscu_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .prev_ok (chain_ok[g]),
        .valid   (cell_valid[g]),
        .entry   (cell_entry[g]),
        .match   (cell_match[g])
      );
    end
  endgenerate

  always_comb begin
    dec_idx = '0;
    for (int i = 0; i < N_CELLS; i++) begin
      if (cell_match[i]) begin
        dec_idx = dec_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    ctl.clear     = 1'b0;
    ctl.push      = 1'b0;
    ctl.push_data = in_char;
    ctl.cmp_char  = in_char;
    state_nxt     = state_r;
    let_nxt       = let_r;
    seen_nxt      = seen_r;
    key_done_nxt  = key_done_r;
    case (state_r)
      kscu_pkg::ST_IDLE: begin
        if (acc_key) begin
          ctl.clear    = key_done_r;
          ctl.push     = (in_char != kscu_pkg::SPACE_CHAR) & ~held;
          seen_nxt     = (key_done_r ? '0 : seen_r) |
                         (is_upper ? (N_CELLS'(1) << chr_idx) : '0);
          key_done_nxt = 1'b0;
          if (in_key_last) begin
            state_nxt = kscu_pkg::ST_FILL;
            let_nxt   = IDX_W'(N_CELLS - 1);
          end
        end
      end
      kscu_pkg::ST_FILL: begin
        ctl.push      = ~seen_r[let_r];
        ctl.push_data = kscu_pkg::LETTER_A + CW'(let_r);
        if (let_r == '0) begin
          state_nxt    = kscu_pkg::ST_IDLE;
          key_done_nxt = 1'b1;
        end else begin
          let_nxt = let_r - 1'b1;
        end
      end
      default: begin
        state_nxt = kscu_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_vld  = 1'b0;
    res_char = kscu_pkg::SPACE_CHAR;
    case (in_action)
      kscu_pkg::ACT_ENC: begin
        if (in_char == kscu_pkg::SPACE_CHAR) begin
          res_vld = 1'b1;
        end else if (is_upper && cell_valid[chr_idx]) begin
          res_vld  = 1'b1;
          res_char = cell_entry[chr_idx];
        end
      end
      kscu_pkg::ACT_DEC: begin
        if (in_char == kscu_pkg::SPACE_CHAR) begin
          res_vld = 1'b1;
        end else if (|cell_match) begin
          res_vld  = 1'b1;
          res_char = kscu_pkg::LETTER_A + CW'(dec_idx);
        end
      end
      default: begin
        res_vld = 1'b0;
      end
    endcase
  end

  assign out_take = out_valid_r & ~out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_char_nxt   = out_char_r;
    skid_valid_nxt = skid_valid_r;
    skid_char_nxt  = skid_char_r;
    if (skid_valid_r) begin
      if (out_take) begin
        out_char_nxt   = skid_char_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_acc && res_vld) begin
      if (!out_valid_r || out_take) begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = res_char;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_char_nxt  = res_char;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= kscu_pkg::ST_IDLE;
      let_r        <= '0;
      seen_r       <= '0;
      key_done_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      let_r        <= let_nxt;
      seen_r       <= seen_nxt;
      key_done_r   <= key_done_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r  <= out_char_nxt;
    skid_char_r <= skid_char_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;

  `KSCU_ASSERT_NOW(a_cells_contiguous, 1'b1, (cell_valid & (cell_valid + 1'b1)) == '0)
  `KSCU_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r)
  `KSCU_ASSERT_NOW(a_fill_stalls_input, state_r == kscu_pkg::ST_FILL, in_stall)
  `KSCU_ASSERT_NEXT(a_last_key_fills, acc_key && in_key_last, state_r == kscu_pkg::ST_FILL)
  `KSCU_ASSERT_NEXT(a_fill_ends_done, state_r == kscu_pkg::ST_FILL && let_r == '0, key_done_r)

endmodule

`default_nettype wire

>>> test/tb.sv
// Testbench for keyword_substitution_cipher_unit: directed table plus random key/message streams
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [kscu_pkg::ACTION_W-1:0] ACT_NONE = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int REQ_TARGET = 950;
  localparam int LONG_HOLD_AT = 400;
  localparam int LONG_HOLD_CYCLES = 120;
  localparam int PRINT_CAP = 50;

  typedef struct packed {
    logic [kscu_pkg::ACTION_W-1:0] act;
    logic [kscu_pkg::CHAR_W-1:0]   ch;
    logic                          last;
    logic                          typed;
    logic                          has_out;
    logic [kscu_pkg::CHAR_W-1:0]   out_c;
  } script_row_t;

  localparam int N_ROWS = 25;

  script_row_t script [0:N_ROWS-1] = '{
    '{kscu_pkg::ACT_ENC, kscu_pkg::SPACE_CHAR, 1'b0, 1'b1, 1'b1, kscu_pkg::SPACE_CHAR},
    '{kscu_pkg::ACT_DEC, kscu_pkg::SPACE_CHAR, 1'b0, 1'b1, 1'b1, kscu_pkg::SPACE_CHAR},
    '{kscu_pkg::ACT_ENC, "A",                  1'b0, 1'b1, 1'b0, 8'h00},
    '{kscu_pkg::ACT_DEC, 8'hFF,                1'b0, 1'b1, 1'b0, 8'h00},
    '{ACT_NONE,          "A",                  1'b1, 1'b1, 1'b0, 8'h00},
    '{kscu_pkg::ACT_KEY, "K",                  1'b0, 1'b0, 1'b0, 8'h00},
    '{kscu_pkg::ACT_KEY, "E",                  1'b0, 1'b0, 1'b0, 8'h00},
    '{kscu_pkg::ACT_KEY, "Y",                  1'b0, 1'b0, 1'b0, 8'h00},
    '{kscu_pkg::ACT_KEY, kscu_pkg::SPACE_CHAR, 1'b0, 1'b0, 1'b0, 8'h00},
    '{kscu_pkg::ACT_KEY, "E",                  1'b0, 1'b0, 1'b0, 8'h00},
    '{kscu_pkg::ACT_KEY, 8'h00,                1'b0, 1'b0, 1'b0, 8'h00},
    '{kscu_pkg::ACT_KEY, 8'hFF,                1'b0, 1'b0, 1'b0, 8'h00},
    '{kscu_pkg::ACT_ENC, "A",                  1'b0, 1'b0, 1'b0, 8'h00},
    '{kscu_pkg::ACT_ENC, "G",                  1'b0, 1'b1, 1'b0, 8'h00},
    '{kscu_pkg::ACT_ENC, "B",                  1'b1, 1'b0, 1'b0, 8'h00},
    '{kscu_pkg::ACT_KEY, "W",                  1'b1, 1'b0, 1'b0, 8'h00},
    '{kscu_pkg::ACT_ENC, "A",                  1'b0, 1'b1, 1'b1, "K"},
    '{kscu_pkg::ACT_ENC, "Z",                  1'b0, 1'b0, 1'b0, 8'h00},
    '{kscu_pkg::ACT_ENC, 8'h61,                1'b0, 1'b1, 1'b0, 8'h00},
    '{kscu_pkg::ACT_ENC, 8'h5B,                1'b0, 1'b1, 1'b0, 8'h00},
    '{kscu_pkg::ACT_DEC, "K",                  1'b0, 1'b1, 1'b1, "A"},
    '{kscu_pkg::ACT_DEC, 8'hFF,                1'b0, 1'b0, 1'b0, 8'h00},
    '{kscu_pkg::ACT_KEY, "Z",                  1'b1, 1'b0, 1'b0, 8'h00},
    '{kscu_pkg::ACT_ENC, "A",                  1'b0, 1'b1, 1'b1, "Z"},
    '{kscu_pkg::ACT_DEC, "A",                  1'b0, 1'b0, 1'b0, 8'h00}
  };

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [kscu_pkg::ACTION_W-1:0] in_action;
  logic [kscu_pkg::CHAR_W-1:0]   in_char;
  logic                          in_key_last;
  logic                          out_valid;
  logic                          out_stall;
  logic [kscu_pkg::CHAR_W-1:0]   out_char;

  logic                          row_typed;
  logic                          row_has_out;
  logic [kscu_pkg::CHAR_W-1:0]   row_out;

  logic [kscu_pkg::CHAR_W-1:0]        key_tbl [0:kscu_pkg::ALPHABET_SIZE-1];
  int                                 key_fill;
  logic [kscu_pkg::ALPHABET_SIZE-1:0] key_seen;
  logic                               key_closed;

  logic [kscu_pkg::CHAR_W-1:0] pending_chars [$];
  int  err_count;
  int  idle_cycles;
  int  sent_reqs;
  bit  tx_burst;
  bit  long_hold_done;

  keyword_substitution_cipher_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_action  (in_action),
    .in_char    (in_char),
    .in_key_last(in_key_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit is_upper(logic [kscu_pkg::CHAR_W-1:0] c);
    return c >= kscu_pkg::LETTER_A && c < kscu_pkg::LETTER_A + kscu_pkg::ALPHABET_SIZE;
  endfunction

  task automatic cipher_predict(input logic [kscu_pkg::ACTION_W-1:0] act,
                                input logic [kscu_pkg::CHAR_W-1:0] c,
                                input logic last, output logic has,
                                output logic [kscu_pkg::CHAR_W-1:0] res);
    int  i;
    int  idx;
    bit  held;
    has = 1'b0;
    res = '0;
    held = 1'b0;
    idx = int'(c) - int'(kscu_pkg::LETTER_A);
    case (act)
      kscu_pkg::ACT_KEY: begin
        if (key_closed) begin
          key_fill = 0;
          key_seen = '0;
          key_closed = 1'b0;
        end
        if (is_upper(c)) key_seen[idx] = 1'b1;
        for (i = 0; i < key_fill; i++)
          if (key_tbl[i] == c) held = 1'b1;
        if (c != kscu_pkg::SPACE_CHAR && !held && key_fill < kscu_pkg::ALPHABET_SIZE) begin
          key_tbl[key_fill] = c;
          key_fill++;
        end
        if (last) begin
          for (i = kscu_pkg::ALPHABET_SIZE - 1; i >= 0; i--)
            if (!key_seen[i] && key_fill < kscu_pkg::ALPHABET_SIZE) begin
              key_tbl[key_fill] = kscu_pkg::LETTER_A + kscu_pkg::CHAR_W'(i);
              key_fill++;
            end
          key_closed = 1'b1;
        end
      end
      kscu_pkg::ACT_ENC: begin
        if (c == kscu_pkg::SPACE_CHAR) begin
          has = 1'b1;
          res = kscu_pkg::SPACE_CHAR;
        end else if (is_upper(c) && idx < key_fill) begin
          has = 1'b1;
          res = key_tbl[idx];
        end
      end
      kscu_pkg::ACT_DEC: begin
        if (c == kscu_pkg::SPACE_CHAR) begin
          has = 1'b1;
          res = kscu_pkg::SPACE_CHAR;
        end else begin
          for (i = 0; i < key_fill; i++)
            if (!has && key_tbl[i] == c) begin
              has = 1'b1;
              res = kscu_pkg::LETTER_A + kscu_pkg::CHAR_W'(i);
            end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, logic [kscu_pkg::CHAR_W-1:0] got,
                                 logic [kscu_pkg::CHAR_W-1:0] want);
    if (err_count < PRINT_CAP)
      $display("MISMATCH %s: out_char got %h want %h", what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin
    logic                        has;
    logic [kscu_pkg::CHAR_W-1:0] res;
    logic [kscu_pkg::CHAR_W-1:0] want;
    bit                          moved;
    moved = 1'b0;
    if (!rst_n) begin
      idle_cycles = 0;
    end else begin
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        cipher_predict(in_action, in_char, in_key_last, has, res);
        if (row_typed) begin
          has = row_has_out;
          res = row_out;
        end
        if (has) pending_chars.push_back(res);
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (pending_chars.size() == 0) begin
          report_mismatch("unexpected result", out_char, '0);
        end else begin
          want = pending_chars.pop_front();
          if (out_char !== want) report_mismatch("wrong char", out_char, want);
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_burst || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  task automatic send_request(input logic [kscu_pkg::ACTION_W-1:0] act,
                              input logic [kscu_pkg::CHAR_W-1:0] c,
                              input logic last, input logic typed = 1'b0,
                              input logic has_out = 1'b0,
                              input logic [kscu_pkg::CHAR_W-1:0] out_c = '0);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_action   <= act;
    in_char     <= c;
    in_key_last <= last;
    row_typed   <= typed;
    row_has_out <= has_out;
    row_out     <= out_c;
    do @(posedge clk); while (in_stall);
    if (act != ACT_NONE) sent_reqs++;
  endtask

  function automatic logic [kscu_pkg::CHAR_W-1:0] key_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)
      return kscu_pkg::LETTER_A +
             kscu_pkg::CHAR_W'($urandom_range(0, kscu_pkg::ALPHABET_SIZE - 1));
    if (r < 80) return kscu_pkg::SPACE_CHAR;
    return kscu_pkg::CHAR_W'($urandom_range(0, 255));
  endfunction

  task automatic send_message_byte(input logic last);
    int                            r;
    logic [kscu_pkg::ACTION_W-1:0] act;
    logic [kscu_pkg::CHAR_W-1:0]   c;
    r = $urandom_range(0, 99);
    act = $urandom_range(0, 1) ? kscu_pkg::ACT_DEC : kscu_pkg::ACT_ENC;
    if (r < 15)
      c = kscu_pkg::SPACE_CHAR;
    else if (r < 30)
      c = kscu_pkg::CHAR_W'($urandom_range(0, 255));
    else if (act == kscu_pkg::ACT_DEC && key_fill > 0 && r < 80)
      c = key_tbl[$urandom_range(0, key_fill - 1)];
    else
      c = kscu_pkg::LETTER_A +
          kscu_pkg::CHAR_W'($urandom_range(0, kscu_pkg::ALPHABET_SIZE - 1));
    send_request(act, c, last);
  endtask

  initial begin
    out_stall = 1'b0;
    long_hold_done = 1'b0;
    forever begin
      int quiet_left;
      int r;
      @(negedge clk);
      if (!long_hold_done && sent_reqs >= LONG_HOLD_AT) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        long_hold_done = 1'b1;
      end else if (quiet_left > 0) begin
        quiet_left--;
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          quiet_left = $urandom_range(20, 80);
          out_stall <= 1'b0;
        end else if (r < 70) begin
          out_stall <= 1'b0;
        end else if (r < 96) begin
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(4, 25)) @(negedge clk);
        end
      end
    end
  end

  initial begin
    int ep;
    int kind;
    int len;
    int k;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_action   = kscu_pkg::ACT_KEY;
    in_char     = '0;
    in_key_last = 1'b0;
    row_typed   = 1'b0;
    row_has_out = 1'b0;
    row_out     = '0;
    key_fill    = 0;
    key_seen    = '0;
    key_closed  = 1'b0;
    err_count   = 0;
    idle_cycles = 0;
    sent_reqs   = 0;
    tx_burst    = 1'b0;
    foreach (key_tbl[i]) key_tbl[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < N_ROWS; k++)
      send_request(script[k].act, script[k].ch, script[k].last, script[k].typed,
                   script[k].has_out, script[k].out_c);

    ep = 0;
    while (sent_reqs < REQ_TARGET) begin
      ep++;
      tx_burst = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 9);
      if (kind <= 6 || kind == 9 || ep == 8) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(27, 34) : $urandom_range(1, 12);
        for (k = 0; k < len; k++) send_request(kscu_pkg::ACT_KEY, key_byte(), k == len - 1);
        len = $urandom_range(4, 24);
        for (k = 0; k < len; k++) send_message_byte(1'b0);
        if (kind == 9 || ep == 8) begin
          @(negedge clk);
          in_valid <= 1'b0;
          while (pending_chars.size() != 0) @(posedge clk);
        end
      end else if (kind == 7) begin
        len = $urandom_range(1, 8);
        for (k = 0; k < len; k++) send_request(kscu_pkg::ACT_KEY, key_byte(), 1'b0);
        len = $urandom_range(3, 10);
        for (k = 0; k < len; k++) send_message_byte($urandom_range(0, 9) == 0);
      end else begin
        len = $urandom_range(5, 15);
        for (k = 0; k < len; k++)
          send_request(kscu_pkg::ACTION_W'($urandom_range(0, 3)),
                       kscu_pkg::CHAR_W'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
